>>> hdl/ssl_pkg.sv
// Shared constants, request codes and controller/datapath link types
// for the swap slot table. No dependencies.
package ssl_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int PID_BITS_DEF   = 16;
  localparam int VPAGE_BITS_DEF = 20;

  localparam int REQ_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int LIMIT_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [REQ_W-1:0] REQ_PUT     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT  = 1'b1;

  typedef struct packed {
    logic start;     // latch a new request and reset the scan
    logic scan_en;   // walk the table
    logic load_out;  // capture the result beat
  } ssl_cmd_t;

  typedef struct packed {
    logic pre_ok;    // request passes its up-front checks
    logic stop_hit;  // put or take found its slot this cycle
    logic scan_end;  // every slot below the limit has been compared
  } ssl_stat_t;

endpackage

>>> hdl/ssl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ssl_ctrl.sv
// Sequencer for the swap slot table: handshakes and scan control.
// Depends on ssl_pkg.
module ssl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ssl_pkg::ssl_stat_t stat,
  output ssl_pkg::ssl_cmd_t  cmd
);
  import ssl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.scan_en  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = stat.pre_ok;
        if (!stat.pre_ok || stat.stop_hit || stat.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the previous result beat has left
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hdl/ssl_datapath.sv
// Datapath of the swap slot table: config registers, occupancy bits,
// owner/page RAM, scan pipeline and result register. Depends on ssl_pkg, ssl_ram.
module ssl_datapath #(
  parameter int SLOTS      = ssl_pkg::SLOTS_DEF,
  parameter int PID_BITS   = ssl_pkg::PID_BITS_DEF,
  parameter int VPAGE_BITS = ssl_pkg::VPAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [ssl_pkg::REQ_W-1:0]        req_type,
  input  logic [PID_BITS-1:0]              proc_id,
  input  logic [VPAGE_BITS-1:0]            virt_page,
  output logic                             ok,
  output logic [ssl_pkg::SLOT_W-1:0]       slot_index,
  output logic [ssl_pkg::COUNT_W-1:0]      used_count,
  input  ssl_pkg::ssl_cmd_t                cmd,
  output ssl_pkg::ssl_stat_t               stat
);
  import ssl_pkg::*;

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int ENTRY_W = PID_BITS + VPAGE_BITS;

  logic                  swap_enable;
  logic [LIMIT_W-1:0]    slot_limit;
  logic [SLOTS-1:0]      owned;
  logic [CNT_W-1:0]      count;

  logic [REQ_W-1:0]      req;
  logic [PID_BITS-1:0]   pid;
  logic [VPAGE_BITS-1:0] page;

  logic [CNT_W-1:0]      issue_cnt;
  logic                  cmp_valid;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;

  logic [ENTRY_W-1:0]    rdata;
  logic                  ram_we;
  logic                  issue_done;
  logic                  match;
  logic                  act;
  logic                  ok_calc;
  logic [31:0]           idx_wide;
  logic [31:0]           cnt_wide;

  ssl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmp_idx),
    .wdata({pid, page}),
    .raddr(issue_cnt[IDX_W-1:0]),
    .rdata(rdata)
  );

  // the scan stops at the table size even if the limit is set higher
  assign issue_done = (issue_cnt == CNT_W'(SLOTS)) ||
                      (32'(issue_cnt) >= 32'(slot_limit));

  always_comb begin
    match = 1'b0;
    unique case (req)
      REQ_PUT:     match = !owned[cmp_idx];
      REQ_TAKE:    match = owned[cmp_idx] && (rdata[ENTRY_W-1:VPAGE_BITS] == pid) &&
                           (rdata[VPAGE_BITS-1:0] == page);
      REQ_RELEASE: match = owned[cmp_idx] && (rdata[ENTRY_W-1:VPAGE_BITS] == pid);
      REQ_UNUSED:  match = 1'b0;
    endcase
  end

  always_comb begin
    stat.pre_ok = 1'b0;
    unique case (req)
      REQ_PUT:     stat.pre_ok = swap_enable && (pid != '0);
      REQ_TAKE:    stat.pre_ok = (pid != '0);
      REQ_RELEASE: stat.pre_ok = (pid != '0);
      REQ_UNUSED:  stat.pre_ok = 1'b0;
    endcase
  end

  assign act           = cmd.scan_en && cmp_valid && match;
  assign ram_we        = act && (req == REQ_PUT);
  assign stat.stop_hit = act && (req != REQ_RELEASE);
  assign stat.scan_end = !cmp_valid && issue_done;
  assign ok_calc       = (req == REQ_RELEASE) ? stat.pre_ok : hit;
  assign idx_wide      = 32'(hit_idx);
  assign cnt_wide      = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_enable <= 1'b0;
      slot_limit  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWAP_ENABLE: swap_enable <= cfg_data[0];
        CFG_SLOT_LIMIT:  slot_limit  <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owned     <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.start) begin
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.scan_en) begin
      cmp_valid <= !issue_done;
      if (act) begin
        if (req == REQ_PUT) begin
          owned[cmp_idx] <= 1'b1;
          count          <= count + CNT_W'(1);
        end else begin
          owned[cmp_idx] <= 1'b0;
          count          <= count - CNT_W'(1);
        end
        if (req != REQ_RELEASE) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req       <= req_type;
      pid       <= proc_id;
      page      <= virt_page;
      issue_cnt <= '0;
      hit_idx   <= '0;
    end else if (cmd.scan_en) begin
      // advance the read address; the compare follows it in the next cycle
      if (!issue_done) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
        cmp_idx   <= issue_cnt[IDX_W-1:0];
      end
      if (stat.stop_hit) begin
        hit_idx <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ok         <= ok_calc;
      slot_index <= idx_wide[SLOT_W-1:0];
      used_count <= cnt_wide[COUNT_W-1:0];
    end
  end

endmodule

>>> hdl/swap_slot_table.sv
// Top level of the swap slot table: controller plus datapath.
// Depends on ssl_pkg, ssl_ctrl, ssl_datapath, ssl_ram.

// Swap slot table. A put claims the lowest free slot below the slot limit,
// a take frees the lowest slot whose owner and page match, a release frees
// every slot of a process id below the limit; each request gives one result
// beat with ok, slot index and the used count after the request. One request
// is in work at a time. A put or take stops the scan on its slot, a release
// scans up to the limit, and no slot is compared when the limit is zero or a
// request fails its checks; a result still waiting on out_ready adds its
// stall. The scan is paced by the owner/page RAM, whose single read port
// walks one slot per cycle.
// Occupancy lives in flip-flop bits cleared by reset, so no clearing pass
// follows reset. A new request is taken while the previous result waits.
module swap_slot_table #(
  parameter int SLOTS      = ssl_pkg::SLOTS_DEF,
  parameter int PID_BITS   = ssl_pkg::PID_BITS_DEF,
  parameter int VPAGE_BITS = ssl_pkg::VPAGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ssl_pkg::REQ_W-1:0]      req_type,
  input  logic [PID_BITS-1:0]            proc_id,
  input  logic [VPAGE_BITS-1:0]          virt_page,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ok,
  output logic [ssl_pkg::SLOT_W-1:0]     slot_index,
  output logic [ssl_pkg::COUNT_W-1:0]    used_count
);
  import ssl_pkg::*;

  ssl_cmd_t  cmd;
  ssl_stat_t stat;

  ssl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssl_datapath #(
    .SLOTS     (SLOTS),
    .PID_BITS  (PID_BITS),
    .VPAGE_BITS(VPAGE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .proc_id   (proc_id),
    .virt_page (virt_page),
    .ok        (ok),
    .slot_index(slot_index),
    .used_count(used_count),
    .cmd       (cmd),
    .stat      (stat)
  );

  // a result beat never appears in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result beat raised directly after accept");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(used_count) <= SLOTS))
    else $error("used count above table size");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (slot_index == '0))
    else $error("failed request reports a nonzero slot");

  // the scan only runs while the controller is neither accepting nor loading a result
  a_scan_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_en |-> !in_ready && !cmd.load_out)
    else $error("scan overlaps accept or result load");

endmodule

>>> bench/tb_swap_slot_table.sv
// Testbench for swap_slot_table: a directed table of requests and register
// writes, then random phases, each beat checked against a typed row's own
// result or an in-bench slot table. Depends on ssl_pkg and swap_slot_table.
module tb_swap_slot_table;
  import ssl_pkg::*;

  localparam int NSLOT        = SLOTS_DEF;
  localparam int PID_W        = PID_BITS_DEF;
  localparam int PAGE_W       = VPAGE_BITS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 60;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] used;
  } swap_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [REQ_W-1:0]      req;
    logic [PID_W-1:0]      pid;
    logic [PAGE_W-1:0]     page;
    bit                    typed;
    swap_result_t          want;
  } plan_row_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [REQ_W-1:0]      req_type  = '0;
  logic [PID_W-1:0]      proc_id   = '0;
  logic [PAGE_W-1:0]     virt_page = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  ok;
  logic [SLOT_W-1:0]     slot_index;
  logic [COUNT_W-1:0]    used_count;

  // predicted slot table and registers
  logic [PID_W-1:0]   own_pid  [NSLOT];
  logic [PAGE_W-1:0]  own_page [NSLOT];
  int                 used_slots  = 0;
  logic               put_enabled = 1'b0;
  logic [LIMIT_W-1:0] limit_reg   = '0;

  swap_result_t result_q [$];
  swap_result_t due_res;
  plan_row_t    plan [$];
  int           err_count   = 0;
  int           cycle_count = 0;
  int           idle_pct    = 0;
  int           hold_left   = 0;

  swap_slot_table DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .proc_id    (proc_id),
    .virt_page  (virt_page),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .slot_index (slot_index),
    .used_count (used_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int visible_span();
    return (limit_reg > NSLOT) ? NSLOT : int'(limit_reg);
  endfunction

  function automatic swap_result_t apply_request(logic [REQ_W-1:0] req,
                                                 logic [PID_W-1:0] pid,
                                                 logic [PAGE_W-1:0] page);
    swap_result_t res;
    int           span;
    bit           done;
    res  = '0;
    done = 1'b0;
    span = visible_span();
    if (req == REQ_PUT && put_enabled && pid != '0) begin
      for (int i = 0; i < span && !done; i++) begin
        if (own_pid[i] == '0) begin
          own_pid[i]  = pid;
          own_page[i] = page;
          used_slots++;
          res.ok   = 1'b1;
          res.slot = SLOT_W'(i);
          done     = 1'b1;
        end
      end
    end else if (req == REQ_TAKE && pid != '0) begin
      for (int i = 0; i < span && !done; i++) begin
        if (own_pid[i] == pid && own_page[i] == page) begin
          own_pid[i] = '0;
          used_slots--;
          res.ok   = 1'b1;
          res.slot = SLOT_W'(i);
          done     = 1'b1;
        end
      end
    end else if (req == REQ_RELEASE && pid != '0) begin
      for (int i = 0; i < span; i++) begin
        if (own_pid[i] == pid) begin
          own_pid[i] = '0;
          used_slots--;
        end
      end
      res.ok = 1'b1;
    end
    res.used = COUNT_W'(used_slots);
    return res;
  endfunction

  // random owned slot below the limit, -1 if none
  function automatic int pick_owned_slot();
    int hits [$];
    for (int i = 0; i < visible_span(); i++) begin
      if (own_pid[i] != '0) hits.push_back(i);
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    row.req     = REQ_PUT;
    row.pid     = '0;
    row.page    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_req(logic [REQ_W-1:0] req, logic [PID_W-1:0] pid,
                                   logic [PAGE_W-1:0] page, bit typed = 1'b0,
                                   logic w_ok = 1'b0, logic [SLOT_W-1:0] w_slot = '0,
                                   logic [COUNT_W-1:0] w_used = '0);
    plan_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = '0;
    row.reg_val = '0;
    row.req     = req;
    row.pid     = pid;
    row.page    = page;
    row.typed   = typed;
    row.want    = {w_ok, w_slot, w_used};
    plan.push_back(row);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_SWAP_ENABLE) begin
      put_enabled = val[0];
    end else begin
      limit_reg = val;
    end
  endtask

  // hold the beat until accepted, then predict; typed rows supply their own result
  task automatic send_req(logic [REQ_W-1:0] req, logic [PID_W-1:0] pid,
                          logic [PAGE_W-1:0] page, bit typed, swap_result_t want);
    swap_result_t res;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    proc_id   <= pid;
    virt_page <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_request(req, pid, page);
    result_q.push_back(typed ? want : res);
  endtask

  always @(posedge clk) begin
    if (idle_pct == 0) begin
      hold_left = 0;
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      hold_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: ok %0d slot %0d used %0d",
                 $time, ok, slot_index, used_count);
        err_count++;
      end else begin
        due_res = result_q.pop_front();
        check_field("ok", 32'(due_res.ok), 32'(ok));
        check_field("slot_index", 32'(due_res.slot), 32'(slot_index));
        check_field("used_count", 32'(due_res.used), 32'(used_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_swap_slot_table: errors");
      $finish;
    end
  end

  initial begin : stim
    int                    sent;
    int                    phase;
    int                    len;
    int                    roll;
    int                    put_pct;
    int                    rel_pct;
    int                    slot;
    logic [REQ_W-1:0]      req;
    logic [PID_W-1:0]      pid;
    logic [PAGE_W-1:0]     page;
    logic [PID_W-1:0]      pid_pool [6];
    logic [CFG_DATA_W-1:0] en_val;
    logic [CFG_DATA_W-1:0] lim_val;

    for (int i = 0; i < NSLOT; i++) begin
      own_pid[i]  = '0;
      own_page[i] = '0;
    end

    // after reset: puts disabled, limit zero
    plan_req(REQ_PUT, 16'd1, 20'h12345, 1, 1'b0, 6'd0, 7'd0);
    plan_req(REQ_TAKE, 16'd1, 20'h12345, 1, 1'b0, 6'd0, 7'd0);
    plan_req(REQ_RELEASE, 16'd0, 20'h0, 1, 1'b0, 6'd0, 7'd0);
    plan_req(REQ_RELEASE, 16'd7, 20'h0, 1, 1'b1, 6'd0, 7'd0);
    plan_req(REQ_UNUSED, 16'hFFFF, 20'hFFFFF, 1, 1'b0, 6'd0, 7'd0);
    plan_cfg(CFG_SWAP_ENABLE, 7'h01);
    plan_req(REQ_PUT, 16'd2, 20'h1, 1, 1'b0, 6'd0, 7'd0);
    // limit above the table size acts as the full table
    plan_cfg(CFG_SLOT_LIMIT, 7'd127);
    plan_req(REQ_PUT, 16'hFFFF, 20'hFFFFF, 1, 1'b1, 6'd0, 7'd1);
    plan_req(REQ_PUT, 16'd0, 20'h3, 1, 1'b0, 6'd0, 7'd1);
    plan_req(REQ_PUT, 16'd1, 20'h0);
    plan_req(REQ_TAKE, 16'hFFFF, 20'h0);
    plan_req(REQ_TAKE, 16'hFFFF, 20'hFFFFF, 1, 1'b1, 6'd0, 7'd1);
    plan_req(REQ_PUT, 16'd2, 20'h5);
    plan_req(REQ_PUT, 16'd2, 20'h5);
    plan_req(REQ_TAKE, 16'd2, 20'h5);
    // lowered limit hides owned slots from every request
    plan_cfg(CFG_SLOT_LIMIT, 7'd1);
    plan_req(REQ_PUT, 16'd3, 20'h9);
    plan_req(REQ_PUT, 16'd3, 20'hA);
    plan_req(REQ_TAKE, 16'd1, 20'h0);
    plan_req(REQ_RELEASE, 16'd2, 20'h0);
    plan_cfg(CFG_SLOT_LIMIT, 7'd64);
    plan_req(REQ_RELEASE, 16'd2, 20'h0);
    plan_req(REQ_TAKE, 16'd1, 20'h0);
    plan_req(REQ_RELEASE, 16'd3, 20'h0);
    plan_req(REQ_UNUSED, 16'd5, 20'h5, 1, 1'b0, 6'd0, 7'd0);
    plan_cfg(CFG_SWAP_ENABLE, 7'h7E);
    plan_req(REQ_PUT, 16'd4, 20'h4, 1, 1'b0, 6'd0, 7'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 25;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_reg(plan[r].reg_sel, plan[r].reg_val);
      end else begin
        send_req(plan[r].req, plan[r].pid, plan[r].page, plan[r].typed, plan[r].want);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        // fill the whole table first
        en_val  = 7'h01;
        lim_val = 7'd127;
        put_pct = 90;
        rel_pct = 0;
        len     = 90;
      end else begin
        en_val = {6'($urandom_range(0, 63)), 1'($urandom_range(0, 4) != 0)};
        case ($urandom_range(0, 6))
          0:       lim_val = 7'd0;
          1:       lim_val = 7'd1;
          2:       lim_val = 7'd63;
          3:       lim_val = 7'd64;
          4:       lim_val = 7'd127;
          default: lim_val = CFG_DATA_W'($urandom_range(2, 127));
        endcase
        put_pct = $urandom_range(20, 80);
        rel_pct = $urandom_range(2, 10);
        len     = $urandom_range(30, 70);
      end
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 35;
      endcase
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_pct = 0;
      write_reg(CFG_SWAP_ENABLE, en_val);
      write_reg(CFG_SLOT_LIMIT, lim_val);
      for (int k = 0; k < 6; k++) pid_pool[k] = PID_W'($urandom_range(1, (1 << PID_W) - 1));
      if ($urandom_range(0, 1) == 1) pid_pool[0] = '1;

      for (int n = 0; n < len && sent < RANDOM_ITEMS; n++) begin
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_pct = 0;
        if (n == len / 2 && $urandom_range(0, 2) == 0) wait_drained();
        pid  = pid_pool[$urandom_range(0, 5)];
        page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
        if ($urandom_range(0, 19) == 0) pid = PID_W'($urandom_range(0, (1 << PID_W) - 1));
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          req = REQ_UNUSED;
        end else if (roll < 6) begin
          req = REQ_W'($urandom_range(0, 2));
          pid = '0;
        end else if (roll < 6 + rel_pct) begin
          req = REQ_RELEASE;
        end else if (roll < 6 + rel_pct + put_pct * (94 - rel_pct) / 100) begin
          req = REQ_PUT;
        end else begin
          req  = REQ_TAKE;
          slot = pick_owned_slot();
          if (slot >= 0 && $urandom_range(0, 4) != 0) begin
            pid  = own_pid[slot];
            page = own_page[slot];
          end
        end
        send_req(req, pid, page, 1'b0, '0);
        if (req != REQ_UNUSED) sent++;
      end
      phase++;
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_swap_slot_table: clean");
    end else begin
      $display("tb_swap_slot_table: errors");
    end
    $finish;
  end

endmodule
